// ----- src/btre_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the bitmap text row emitter.
// No dependencies; every other file except btre_ram refers to it by scoped names.
package btre_pkg;

	// Default sizes and fixed glyph geometry
	localparam int FONT_BYTES_DEF     = 4096;
	localparam int MAX_GLYPH_ROWS_DEF = 16;
	localparam int GLYPH_WIDTH        = 8;
	localparam int QUEUE_DEPTH        = 2;

	// Character codes
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] END_CODE     = 8'd0;

	// Input selector
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TEXT = 1'b1;

	// Classified operations handed from front to back
	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_NEWLINE = 2'd1;
	localparam logic [1:0] OP_END     = 2'd2;
	localparam logic [1:0] OP_CHAR    = 2'd3;

	// Result kinds
	localparam logic KIND_ROW  = 1'b0;
	localparam logic KIND_AREA = 1'b1;

	// Register map (index = paddr[4:2])
	localparam int         APB_AW         = 5;
	localparam int         APB_DW         = 32;
	localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] REG_SCALE      = 3'd2;
	localparam logic [2:0] REG_MIRROR     = 3'd3;
	localparam logic [2:0] REG_HEIGHT     = 3'd4;
	localparam logic [2:0] REG_FONT_LEN   = 3'd5;
	localparam logic [2:0] REG_COLOR      = 3'd6;

	localparam logic [3:0] SCALE_RST  = 4'd1;
	localparam logic [4:0] HEIGHT_RST = 5'd8;

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [3:0]  pixel_scale;
		logic        mirror_mode;
		logic [4:0]  glyph_height;
		logic [12:0] font_length;
		logic [15:0] draw_color;
	} cfg_t;

	// Cursor line reload on an origin_y write
	typedef struct packed {
		logic        en;
		logic [15:0] value;
	} line_load_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] font_addr;
		logic [7:0]  font_byte;
		logic [7:0]  text_char;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  column_mask;
		logic [3:0]  pixel_size;
		logic [15:0] color;
		logic [15:0] area_width;
		logic [15:0] area_height;
		logic        last;
	} result_t;

	// Clamp a signed value to the signed 16-bit range
	function automatic logic [15:0] sat_s16(input logic signed [31:0] v);
		logic [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -32'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Clamp a signed value to 0..65535
	function automatic logic [15:0] sat_u16(input logic signed [31:0] v);
		logic [15:0] r;
		if (v > 32'sd65535) begin
			r = 16'hFFFF;
		end else if (v < 32'sd0) begin
			r = 16'h0000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = b[i];
		end
		return r;
	endfunction

endpackage

// ----- src/bitmap_text_row_emitter.sv -----
`timescale 1ns / 1ps
// Bitmap text row emitter, top level. A font load writes the font RAM when popped. A
// character runs pop, prep, one font RAM row read per cycle unless the output stalls,
// a drain of the read stage and flush; a newline pop, prep and line; an end of string
// pop, prep, line and area. Each row result waits for the next nonzero row; the last
// goes out in flush. Output stalls hold the back end; the input queue holds 2 items.
// arst_n clears cursor, queue and output valid; the font RAM is not cleared.
module bitmap_text_row_emitter #(
	parameter int FONT_BYTES     = btre_pkg::FONT_BYTES_DEF,
	parameter int MAX_GLYPH_ROWS = btre_pkg::MAX_GLYPH_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // font_addr[11:0], font_byte[19:12],
	                                                   // text_char[27:20]
	input  logic [0:0]                  s_axis_tuser,  // func[0]
	// result stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [95:0]                 m_axis_tdata,  // pos_x[15:0], pos_y[31:16],
	                                                   // column_mask[39:32], pixel_size[43:40],
	                                                   // color[59:44], area_width[75:60],
	                                                   // area_height[91:76]
	output logic [0:0]                  m_axis_tuser,  // kind[0]
	output logic                        m_axis_tlast,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btre_pkg::APB_AW-1:0] paddr,
	input  logic [btre_pkg::APB_DW-1:0] pwdata,
	output logic [btre_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	btre_pkg::cfg_t       cfg;
	btre_pkg::line_load_t line_load;
	btre_pkg::cmd_t       cmd;
	btre_pkg::result_t    res;
	logic                 cmd_valid;
	logic                 cmd_pop;

	btre_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.line_load (line_load)
	);

	btre_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	btre_back #(
		.FONT_BYTES     (FONT_BYTES),
		.MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.line_load (line_load),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack the result transaction
	assign m_axis_tdata = {4'd0, res.area_height, res.area_width, res.color,
	                       res.pixel_size, res.column_mask, res.pos_y, res.pos_x};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

// ----- src/btre_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/btre_cfg.sv -----
`timescale 1ns / 1ps
// APB register bank for the text row emitter (origin, scale, mirror, height,
// font length, color). Depends on btre_pkg.
module btre_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [btre_pkg::APB_AW-1:0]   paddr,
	input  logic [btre_pkg::APB_DW-1:0]   pwdata,
	output logic [btre_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output btre_pkg::cfg_t                cfg,
	output btre_pkg::line_load_t          line_load
);

	btre_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// origin_y writes also move the cursor line
	assign line_load.en    = wr && (idx == btre_pkg::REG_ORIGIN_Y);
	assign line_load.value = pwdata[15:0];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
			cfg_q.pixel_scale  <= btre_pkg::SCALE_RST;
			cfg_q.mirror_mode  <= 1'b0;
			cfg_q.glyph_height <= btre_pkg::HEIGHT_RST;
			cfg_q.font_length  <= '0;
			cfg_q.draw_color   <= '0;
		end else if (wr) begin
			case (idx)
				btre_pkg::REG_ORIGIN_X: cfg_q.origin_x     <= pwdata[15:0];
				btre_pkg::REG_ORIGIN_Y: cfg_q.origin_y     <= pwdata[15:0];
				btre_pkg::REG_SCALE:    cfg_q.pixel_scale  <= pwdata[3:0];
				btre_pkg::REG_MIRROR:   cfg_q.mirror_mode  <= pwdata[0];
				btre_pkg::REG_HEIGHT:   cfg_q.glyph_height <= pwdata[4:0];
				btre_pkg::REG_FONT_LEN: cfg_q.font_length  <= pwdata[12:0];
				btre_pkg::REG_COLOR:    cfg_q.draw_color   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			btre_pkg::REG_ORIGIN_X: prdata = {16'd0, cfg_q.origin_x};
			btre_pkg::REG_ORIGIN_Y: prdata = {16'd0, cfg_q.origin_y};
			btre_pkg::REG_SCALE:    prdata = {28'd0, cfg_q.pixel_scale};
			btre_pkg::REG_MIRROR:   prdata = {31'd0, cfg_q.mirror_mode};
			btre_pkg::REG_HEIGHT:   prdata = {27'd0, cfg_q.glyph_height};
			btre_pkg::REG_FONT_LEN: prdata = {19'd0, cfg_q.font_length};
			btre_pkg::REG_COLOR:    prdata = {16'd0, cfg_q.draw_color};
			default:                prdata = '0;
		endcase
	end

endmodule

// ----- src/btre_front.sv -----
`timescale 1ns / 1ps
// Input side: takes stream transactions, classifies them into load / newline /
// end / character operations and queues them for the back end. Uses btre_pkg.
module btre_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [31:0]    s_axis_tdata,  // font_addr[11:0], font_byte[19:12], text_char[27:20]
	input  logic [0:0]     s_axis_tuser,  // func[0]
	output logic           cmd_valid,
	output btre_pkg::cmd_t cmd,
	input  logic           cmd_pop
);

	localparam int QD  = btre_pkg::QUEUE_DEPTH;
	localparam int QAW = $clog2(QD);

	btre_pkg::cmd_t entry_q [QD];
	btre_pkg::cmd_t new_cmd;
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;

	// Classify the incoming transaction
	always_comb begin
		new_cmd.font_addr = s_axis_tdata[11:0];
		new_cmd.font_byte = s_axis_tdata[19:12];
		new_cmd.text_char = s_axis_tdata[27:20];
		if (s_axis_tuser[0] == btre_pkg::FUNC_LOAD) begin
			new_cmd.op = btre_pkg::OP_LOAD;
		end else if (new_cmd.text_char == btre_pkg::NEWLINE_CODE) begin
			new_cmd.op = btre_pkg::OP_NEWLINE;
		end else if (new_cmd.text_char == btre_pkg::END_CODE) begin
			new_cmd.op = btre_pkg::OP_END;
		end else begin
			new_cmd.op = btre_pkg::OP_CHAR;
		end
	end

	assign s_axis_tready = (count_q != (QAW + 1)'(QD));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (count_q != '0);
	assign cmd           = entry_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + (QAW + 1)'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - (QAW + 1)'(1);
			end
		end
	end

endmodule

// ----- src/btre_back.sv -----
`timescale 1ns / 1ps
// Back end: executes queued operations, owns the font RAM and the text cursor,
// walks glyph rows and drives the result register. Uses btre_pkg, btre_ram.
module btre_back #(
	parameter int FONT_BYTES     = btre_pkg::FONT_BYTES_DEF,
	parameter int MAX_GLYPH_ROWS = btre_pkg::MAX_GLYPH_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btre_pkg::cfg_t       cfg,
	input  btre_pkg::line_load_t line_load,
	input  logic                 cmd_valid,
	input  btre_pkg::cmd_t       cmd,
	output logic                 cmd_pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output btre_pkg::result_t    res
);

	localparam int AW  = $clog2(FONT_BYTES);
	localparam int HW  = $clog2(MAX_GLYPH_ROWS + 1);
	localparam int OW  = 8 + HW;
	localparam int SHW = HW + 4;
	localparam int PW  = 16 + $clog2(btre_pkg::GLYPH_WIDTH) + 4;
	localparam int XW  = PW + 2;
	localparam logic signed [XW-1:0] WIDEST_LIM = XW'(131071);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_LINE  = 3'd2;
	localparam logic [2:0] ST_AREA  = 3'd3;
	localparam logic [2:0] ST_ROWS  = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]             state_q;
	logic [1:0]             op_q;
	logic [7:0]             char_q;
	logic signed [XW-1:0]   endx_q;
	logic [OW-1:0]          base_q;
	logic [HW-1:0]          r_q;
	logic                   valid_s1;
	logic [HW-1:0]          r_s1;
	logic                   inr_s1;
	logic                   pend_valid_q;
	logic [15:0]            pend_y_q;
	logic [7:0]             pend_mask_q;
	logic [15:0]            column_q;
	logic [15:0]            line_y_q;
	logic [16:0]            widest_q;
	logic                   out_valid_q;
	btre_pkg::result_t      out_q;

	logic [3:0]             scale;
	logic [HW-1:0]          height;
	logic [SHW-1:0]         hs;
	logic                   slot_free;
	logic [PW-1:0]          prod;
	logic signed [XW-1:0]   endx_next;
	logic [OW-1:0]          base_next;
	logic signed [XW-1:0]   e_clip;
	logic [16:0]            widest_next;
	logic [15:0]            line_y_next;
	logic [15:0]            area_w;
	logic [15:0]            area_h;
	logic [OW-1:0]          off;
	logic                   inrange;
	logic                   load_ok;
	logic                   ram_we;
	logic                   ram_re;
	logic [7:0]             rdata;
	logic [7:0]             glyph_b;
	logic [HW-1:0]          rp;
	logic [SHW-1:0]         rp_off;
	logic [15:0]            row_y;
	logic [7:0]             row_mask;
	logic [15:0]            pos_x;
	logic                   hit;
	logic                   stall;
	logic                   issue;
	logic [31:0]            line_y_ext;

	// Effective scale and height
	assign scale  = (cfg.pixel_scale == 4'd0) ? 4'd1 : cfg.pixel_scale;
	assign height = (32'(cfg.glyph_height) > MAX_GLYPH_ROWS) ? HW'(MAX_GLYPH_ROWS)
	                                                         : HW'(cfg.glyph_height);
	assign hs     = SHW'(height) * SHW'(scale);

	assign slot_free  = !out_valid_q || res_ready;
	assign line_y_ext = {{16{line_y_q[15]}}, line_y_q};

	// Line end x and glyph base offset, registered in the prep cycle
	assign prod      = PW'(column_q) * PW'(btre_pkg::GLYPH_WIDTH) * PW'(scale);
	assign endx_next = $signed({{(XW - 16){cfg.origin_x[15]}}, cfg.origin_x})
	                   + $signed({2'b00, prod});
	assign base_next = OW'(char_q) * OW'(height);

	// Widest line end update
	assign e_clip      = (endx_q > WIDEST_LIM) ? WIDEST_LIM : endx_q;
	assign widest_next = (e_clip > $signed({{(XW - 17){1'b0}}, widest_q})) ? e_clip[16:0]
	                                                                        : widest_q;
	assign line_y_next = btre_pkg::sat_s16($signed(line_y_ext + 32'(hs)));

	// Bounding area of the finished string
	assign area_w = btre_pkg::sat_u16($signed({15'd0, widest_q})
	                                  - $signed({{16{cfg.origin_x[15]}}, cfg.origin_x}));
	assign area_h = btre_pkg::sat_u16($signed(line_y_ext + 32'(hs))
	                                  - $signed({{16{cfg.origin_y[15]}}, cfg.origin_y}));

	// Row address issue
	assign off     = base_q + OW'(r_q);
	assign inrange = (32'(off) < 32'(cfg.font_length)) && (32'(off) < 32'(FONT_BYTES));
	assign load_ok = 32'(cmd.font_addr) < 32'(FONT_BYTES);

	// Row data consume (stage 1)
	assign glyph_b  = inr_s1 ? rdata : 8'd0;
	assign rp       = cfg.mirror_mode ? (height - HW'(1) - r_s1) : r_s1;
	assign rp_off   = SHW'(rp) * SHW'(scale);
	assign row_y    = btre_pkg::sat_s16($signed(line_y_ext + 32'(rp_off)));
	assign row_mask = cfg.mirror_mode ? glyph_b : btre_pkg::reverse8(glyph_b);
	assign pos_x    = btre_pkg::sat_s16($signed({{(32 - XW){endx_q[XW-1]}}, endx_q}));

	assign hit   = valid_s1 && (glyph_b != 8'd0);
	assign stall = hit && pend_valid_q && !slot_free;
	assign issue = (state_q == ST_ROWS) && !stall && (r_q < height);

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign ram_we  = cmd_pop && (cmd.op == btre_pkg::OP_LOAD) && load_ok;
	assign ram_re  = issue;

	btre_ram #(
		.WIDTH (8),
		.DEPTH (FONT_BYTES)
	) u_font_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.font_addr)),
		.wdata (cmd.font_byte),
		.re    (ram_re),
		.raddr (AW'(off)),
		.rdata (rdata)
	);

	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Sequencer, cursor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= btre_pkg::OP_LOAD;
			char_q       <= '0;
			endx_q       <= '0;
			base_q       <= '0;
			r_q          <= '0;
			valid_s1     <= 1'b0;
			r_s1         <= '0;
			inr_s1       <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_y_q     <= '0;
			pend_mask_q  <= '0;
			column_q     <= '0;
			line_y_q     <= '0;
			widest_q     <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (res_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						op_q   <= cmd.op;
						char_q <= cmd.text_char;
						if (cmd.op != btre_pkg::OP_LOAD) begin
							state_q <= ST_PREP;
						end
					end
				end

				ST_PREP: begin
					endx_q   <= endx_next;
					base_q   <= base_next;
					r_q      <= '0;
					valid_s1 <= 1'b0;
					state_q  <= (op_q == btre_pkg::OP_CHAR) ? ST_ROWS : ST_LINE;
				end

				ST_LINE: begin
					widest_q <= widest_next;
					if (op_q == btre_pkg::OP_NEWLINE) begin
						line_y_q <= line_y_next;
						column_q <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_AREA;
					end
				end

				ST_AREA: begin
					if (slot_free) begin
						out_q.kind        <= btre_pkg::KIND_AREA;
						out_q.pos_x       <= cfg.origin_x;
						out_q.pos_y       <= cfg.origin_y;
						out_q.column_mask <= '0;
						out_q.pixel_size  <= scale;
						out_q.color       <= cfg.draw_color;
						out_q.area_width  <= area_w;
						out_q.area_height <= area_h;
						out_q.last        <= 1'b1;
						out_valid_q       <= 1'b1;
						column_q          <= '0;
						line_y_q          <= cfg.origin_y;
						widest_q          <= '0;
						state_q           <= ST_IDLE;
					end
				end

				ST_ROWS: begin
					if (!stall) begin
						if (issue) begin
							r_q      <= r_q + HW'(1);
							valid_s1 <= 1'b1;
							r_s1     <= r_q;
							inr_s1   <= inrange;
						end else begin
							valid_s1 <= 1'b0;
						end
						// A new nonzero row pushes the held one out as non-final
						if (hit) begin
							pend_valid_q <= 1'b1;
							pend_y_q     <= row_y;
							pend_mask_q  <= row_mask;
							if (pend_valid_q) begin
								out_q.kind        <= btre_pkg::KIND_ROW;
								out_q.pos_x       <= pos_x;
								out_q.pos_y       <= pend_y_q;
								out_q.column_mask <= pend_mask_q;
								out_q.pixel_size  <= scale;
								out_q.color       <= cfg.draw_color;
								out_q.area_width  <= '0;
								out_q.area_height <= '0;
								out_q.last        <= 1'b0;
								out_valid_q       <= 1'b1;
							end
						end
						if (!issue && !valid_s1) begin
							state_q <= ST_FLUSH;
						end
					end
				end

				ST_FLUSH: begin
					if (!pend_valid_q || slot_free) begin
						if (pend_valid_q) begin
							out_q.kind        <= btre_pkg::KIND_ROW;
							out_q.pos_x       <= pos_x;
							out_q.pos_y       <= pend_y_q;
							out_q.column_mask <= pend_mask_q;
							out_q.pixel_size  <= scale;
							out_q.color       <= cfg.draw_color;
							out_q.area_width  <= '0;
							out_q.area_height <= '0;
							out_q.last        <= 1'b1;
							out_valid_q       <= 1'b1;
							pend_valid_q      <= 1'b0;
						end
						if (column_q != 16'hFFFF) begin
							column_q <= column_q + 16'd1;
						end
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase

			if (line_load.en) begin
				line_y_q <= line_load.value;
			end
		end
	end

endmodule
